// ----- design/assert_macros.svh -----
// assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`endif

// ----- design/w3c_pkg.sv -----
package w3c_pkg;
  localparam int MaxWidth = 2048;
  localparam int AddrW = $clog2(MaxWidth);
  localparam int QDepth = 4;
  localparam int QAddrW = $clog2(QDepth);
  localparam logic [1:0] CfgWidth = 2'd0;
  localparam logic [1:0] CfgHeight = 2'd1;
  localparam logic [1:0] CfgKernel = 2'd2;

  // one window job handed from front to back
  typedef struct packed {
    logic [8:0][7:0] win;
    logic            do_a;
    logic            do_b;
    logic            do_c;
    logic            do_d;
    logic [15:0]     row;
    logic [10:0]     col;
  } job_t;

  typedef struct packed {
    logic [7:0]  pix;
    logic [15:0] row;
    logic [10:0] col;
    logic        run_last;
    logic        frame_done;
  } res_t;
endpackage

// ----- design/w3c_if.sv -----
interface w3c_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_in;
  modport source(output valid, output pixel_in, input ready);
  modport sink(input valid, input pixel_in, output ready);
endinterface

interface w3c_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  pixel_out;
  logic [15:0] out_row;
  logic [10:0] out_col;
  logic        run_last;
  logic        frame_done;
  modport source(output valid, output pixel_out, output out_row, output out_col,
                 output run_last, output frame_done, input ready);
  modport sink(input valid, input pixel_out, input out_row, input out_col,
               input run_last, input frame_done, output ready);
endinterface

// ----- design/window_3x3_convolution_core.sv -----
// An accepted pixel passes stage 1, the job queue and the MAC and result registers.
// Throughput: one pixel per cycle and one result beat per cycle from the shared MAC unless
// back-pressure stalls; inputs with several results (row ends, last row) emit them in turn.
// Line stores are simple dual-port RAMs, read on accept and written when the
// window leaves stage 1.
// Reset (rst_n, synchronous, low): counters, window and queues clear; RAMs are not cleared.
module window_3x3_convolution_core (
  input  logic        clk,
  input  logic        rst_n,
  w3c_in_if.sink      in_ch,
  w3c_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [35:0] cfg_data
);
  import w3c_pkg::*;

  logic [11:0] w_r;
  logic [15:0] h_r;
  logic [35:0] k_r;
  logic [11:0] w_eff;
  logic [15:0] h_eff;
  logic        jv, jr;
  job_t        job;
  res_t        res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r <= 12'd640; h_r <= 16'd480; k_r <= 36'hFEF000121;
    end else if (cfg_we) begin
      case (cfg_index)
        CfgWidth:  w_r <= cfg_data[11:0];
        CfgHeight: h_r <= cfg_data[15:0];
        CfgKernel: k_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign w_eff = (w_r < 12'd2) ? 12'd2 : (w_r > 12'(MaxWidth) ? 12'(MaxWidth) : w_r);
  assign h_eff = (h_r < 16'd2) ? 16'd2 : h_r;

  w3c_front u_front (.clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid),
    .in_ready(in_ch.ready), .in_pix(in_ch.pixel_in), .w_eff(w_eff), .h_eff(h_eff),
    .job_valid(jv), .job_ready(jr), .job(job));

  w3c_back u_back (.clk(clk), .rst_n(rst_n), .job_valid(jv), .job_ready(jr),
    .job(job), .coeffs(k_r), .w_eff(w_eff), .h_eff(h_eff),
    .res_valid(out_ch.valid), .res_ready(out_ch.ready), .res(res));

  assign out_ch.pixel_out  = res.pix;
  assign out_ch.out_row    = res.row;
  assign out_ch.out_col    = res.col;
  assign out_ch.run_last   = res.run_last;
  assign out_ch.frame_done = res.frame_done;
endmodule

// ----- design/w3c_ram.sv -----
module w3c_ram #(
  parameter int Width = 8,
  parameter int Depth = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ----- design/w3c_front.sv -----
module w3c_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [7:0]    in_pix,
  input  logic [11:0]   w_eff,
  input  logic [15:0]   h_eff,
  output logic          job_valid,
  input  logic          job_ready,
  output w3c_pkg::job_t job
);
  import w3c_pkg::*;
  `include "assert_macros.svh"

  logic [15:0] row_r;
  logic [10:0] col_r;
  logic [15:0] y;
  logic [11:0] x;
  logic        acc;
  logic [7:0]  top_q, mid_q;
  // stage 1: pixel registered while stores are read
  logic        s1_v_r;
  logic [7:0]  s1_p_r;
  logic [15:0] s1_y_r;
  logic [11:0] s1_x_r;
  logic [8:0][7:0] win_r, win_nxt;
  logic [7:0]  top, mid;
  logic        s1_go;
  logic [AddrW-1:0] addr;

  always_comb begin
    x = {1'b0, col_r};
    y = row_r;
    if (x >= w_eff || y >= h_eff) begin
      x = '0;
      y = '0;
    end
  end

  assign s1_go = s1_v_r && job_ready;
  // stage 1 holds when back is stalled; stores are only written when stage 1 hands on
  assign in_ready = !s1_v_r || job_ready;
  assign acc = in_valid && in_ready;
  // read on accept, re-read the held column while stalled
  assign addr = acc ? x[AddrW-1:0] : s1_x_r[AddrW-1:0];

  // write happens when stage 1 hands its window on
  w3c_ram #(.Width(8), .Depth(MaxWidth)) u_old (
    .clk(clk), .we(s1_go), .waddr(s1_x_r[AddrW-1:0]), .wdata(mid),
    .raddr(addr), .rdata(top_q));
  w3c_ram #(.Width(8), .Depth(MaxWidth)) u_rec (
    .clk(clk), .we(s1_go), .waddr(s1_x_r[AddrW-1:0]), .wdata(s1_p_r),
    .raddr(addr), .rdata(mid_q));

  assign top = (s1_y_r == 16'd0) ? s1_p_r : top_q;
  assign mid = (s1_y_r == 16'd0) ? s1_p_r : mid_q;

  always_comb begin
    logic [2:0][7:0] v;
    v[0] = top;
    v[1] = mid;
    v[2] = s1_p_r;
    win_nxt = win_r;
    for (int r = 0; r < 3; r++) begin
      if (s1_x_r == 12'd0) begin
        win_nxt[r*3]   = v[r];
        win_nxt[r*3+1] = v[r];
      end else begin
        win_nxt[r*3]   = win_r[r*3+1];
        win_nxt[r*3+1] = win_r[r*3+2];
      end
      win_nxt[r*3+2] = v[r];
    end
  end

  always_comb begin
    logic edge_x;
    edge_x = (s1_x_r == w_eff - 12'd1);
    job.win  = win_nxt;
    job.row  = s1_y_r;
    job.col  = s1_x_r[10:0];
    job.do_a = (s1_y_r != 16'd0) && (s1_x_r != 12'd0);
    job.do_b = job.do_a && edge_x;
    job.do_c = (s1_y_r == h_eff - 16'd1) && (s1_x_r != 12'd0);
    job.do_d = job.do_c && edge_x;
  end
  assign job_valid = s1_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r  <= '0;
      col_r  <= '0;
      s1_v_r <= 1'b0;
      win_r  <= '0;
    end else begin
      if (s1_go) win_r <= win_nxt;
      if (acc) begin
        s1_v_r <= 1'b1;
        if (x + 12'd1 >= w_eff) begin
          col_r <= '0;
          row_r <= (y + 16'd1 >= h_eff) ? 16'd0 : y + 16'd1;
        end else begin
          col_r <= x[10:0] + 11'd1;
          row_r <= y;
        end
      end else if (s1_go) begin
        s1_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_p_r <= in_pix;
      s1_y_r <= y;
      s1_x_r <= x;
    end
  end

  `ASSERT_CLK(a_hold, s1_v_r && !job_ready |=> s1_v_r && $stable(s1_x_r), "stage lost")
  `ASSERT_CLK(a_col, s1_v_r |-> s1_x_r < w_eff, "column out of frame")
  `ASSERT_NEVER(a_acc_held, acc && s1_v_r && !job_ready, "beat taken into a held stage")
endmodule

// ----- design/w3c_back.sv -----
module w3c_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          job_valid,
  output logic          job_ready,
  input  w3c_pkg::job_t job,
  input  logic [35:0]   coeffs,
  input  logic [11:0]   w_eff,
  input  logic [15:0]   h_eff,
  output logic          res_valid,
  input  logic          res_ready,
  output w3c_pkg::res_t res
);
  import w3c_pkg::*;
  `include "assert_macros.svh"

  // job queue
  job_t q_r [QDepth];
  logic [QAddrW-1:0] wp_r, rp_r;
  logic [QAddrW:0]   cnt_r;
  logic [1:0]        sub_r;
  job_t hj;
  logic [3:0] mask;
  logic [1:0] sel;
  logic       has, more, emit, pop, push;
  logic [1:0] nsub;

  assign job_ready = cnt_r < (QAddrW+1)'(QDepth);
  assign push = job_valid && job_ready;
  assign hj = q_r[rp_r];
  assign mask = {hj.do_d, hj.do_c, hj.do_b, hj.do_a};

  // pick next subresult at or after sub_r
  always_comb begin
    has = 1'b0;
    sel = '0;
    for (int i = 3; i >= 0; i--) begin
      if (mask[i] && 2'(i) >= sub_r) begin
        has = 1'b1;
        sel = 2'(i);
      end
    end
    more = 1'b0;
    for (int i = 0; i < 4; i++) begin
      if (mask[i] && 2'(i) > sel) more = 1'b1;
    end
  end

  // output stage: mac stage then result register
  logic       m_v_r;
  logic signed [15:0] m_acc_r;
  logic [15:0] m_row_r;
  logic [10:0] m_col_r;
  logic        m_last_r, m_fd_r;
  logic        o_v_r;
  res_t        o_r;
  logic        m_adv;
  logic signed [15:0] m_acc_nxt;
  logic [15:0] m_row_nxt;
  logic [10:0] m_col_nxt;
  logic        m_fd_nxt;

  assign m_adv = !m_v_r || !o_v_r || res_ready;
  assign emit = cnt_r != '0 && (has || 1'b1) && m_adv;
  assign pop = emit && (!has || !more);
  assign nsub = sel + 2'd1;

  always_comb begin
    logic signed [15:0] a;
    logic [1:0] rs [3];
    logic [1:0] cs [3];
    logic [15:0] r;
    logic [11:0] c;
    a = '0;
    for (int k = 0; k < 3; k++) begin
      rs[k] = sel[1] ? ((k == 0) ? 2'd1 : 2'd2) : 2'(k);
      cs[k] = sel[0] ? ((k == 0) ? 2'd1 : 2'd2) : 2'(k);
    end
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        a = a + $signed({8'd0, hj.win[rs[i]*3+cs[j]]}) *
                $signed(coeffs[(i*3+j)*4 +: 4]);
    m_acc_nxt = a;
    r = sel[1] ? hj.row : hj.row - 16'd1;
    c = sel[0] ? {1'b0, hj.col} : {1'b0, hj.col} - 12'd1;
    m_row_nxt = r;
    m_col_nxt = c[10:0];
    m_fd_nxt = (r == h_eff - 16'd1) && (c == w_eff - 12'd1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0; sub_r <= '0;
      m_v_r <= 1'b0; o_v_r <= 1'b0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop) begin
        rp_r <= rp_r + 1'b1;
        sub_r <= '0;
      end else if (emit) begin
        sub_r <= nsub;
      end
      cnt_r <= cnt_r + (QAddrW+1)'(push) - (QAddrW+1)'(pop);
      if (m_adv) m_v_r <= emit && has;
      if (!o_v_r || res_ready) o_v_r <= m_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= job;
    if (m_adv) begin
      m_acc_r <= m_acc_nxt;
      m_row_r <= m_row_nxt;
      m_col_r <= m_col_nxt;
      m_last_r <= !more;
      m_fd_r <= m_fd_nxt;
    end
    if (!o_v_r || res_ready) begin
      o_r.pix <= m_acc_r < 0 ? 8'd0 : (m_acc_r > 16'sd255 ? 8'd255 : m_acc_r[7:0]);
      o_r.row <= m_row_r;
      o_r.col <= m_col_r;
      o_r.run_last <= m_last_r;
      o_r.frame_done <= m_fd_r;
    end
  end

  assign res_valid = o_v_r;
  assign res = o_r;

  `ASSERT_CLK(a_stall, o_v_r && !res_ready |=> o_v_r && $stable(o_r), "result dropped")
  `ASSERT_CLK(a_cnt, cnt_r <= (QAddrW+1)'(QDepth), "queue overflow")
  `ASSERT_NEVER(a_pop_empty, pop && cnt_r == '0, "pop from empty queue")
endmodule
